// ===== hdl/lcgja_pkg.sv =====
// Shared types and constants for the 128-bit LCG jump-ahead block.
package lcgja_pkg;

  localparam int LCG_BITS_DEF = 128;
  localparam int FIELD_W      = 64;
  localparam int FULL_W       = 2 * FIELD_W;
  localparam int LIMB_W       = 32;
  localparam int CFG_IDX_W    = 2;

  typedef struct packed {
    logic [FIELD_W-1:0] state_high;
    logic [FIELD_W-1:0] state_low;
    logic [FIELD_W-1:0] steps_high;
    logic [FIELD_W-1:0] steps_low;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] next_high;
    logic [FIELD_W-1:0] next_low;
  } result_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULT_HIGH,
    REG_MULT_LOW,
    REG_INCR_HIGH,
    REG_INCR_LOW
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOP,
    S_AM,
    S_AM_WAIT,
    S_AP,
    S_AP_WAIT,
    S_CP,
    S_CP_WAIT,
    S_CM,
    S_CM_WAIT,
    S_FIN,
    S_FIN_WAIT
  } lcgja_state_t;

endpackage

// ===== hdl/lcgja_mul.sv =====
// Iterative multiply-add modulo 2^WIDTH on one shared 32x32 multiplier.
module lcgja_mul #(
  parameter int WIDTH = lcgja_pkg::LCG_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] c,
  output logic             done,
  output logic [WIDTH-1:0] prod
);
  import lcgja_pkg::*;

  localparam int NL = (WIDTH + LIMB_W - 1) / LIMB_W;
  localparam int LW = NL * LIMB_W;
  localparam int SW = LW + LIMB_W;
  localparam int IW = (NL > 1) ? $clog2(NL) : 1;
  localparam logic [IW-1:0] LAST_LIMB = IW'(NL - 1);

  logic [NL-1:0][LIMB_W-1:0] a_q;
  logic [NL-1:0][LIMB_W-1:0] b_q;
  logic [WIDTH-1:0]          acc;
  logic [IW-1:0]             i;
  logic [IW-1:0]             j;
  logic                      run;
  logic [2*LIMB_W-1:0]       pp;
  logic [IW-1:0]             sh;
  logic                      pp_vld;
  logic                      pp_last;
  logic                      last_pair;
  logic                      row_end;
  logic [SW-1:0]             shifted;

  assign last_pair = (i == LAST_LIMB) && (j == '0);
  assign row_end   = (IW'(i + j) == LAST_LIMB);
  assign shifted   = SW'(pp) << {sh, 5'b0};
  assign prod      = acc;

  // Issue one partial product per cycle over the lower triangle of limbs.
  always_ff @(posedge clk) begin
    if (rst) begin
      run     <= 1'b0;
      pp_vld  <= 1'b0;
      pp_last <= 1'b0;
      done    <= 1'b0;
      i       <= '0;
      j       <= '0;
    end else begin
      pp_vld <= run;
      done   <= pp_vld && pp_last;
      if (start) begin
        run <= 1'b1;
        i   <= '0;
        j   <= '0;
      end else if (run) begin
        pp_last <= last_pair;
        if (last_pair) begin
          run <= 1'b0;
        end else if (row_end) begin
          i <= i + 1'b1;
          j <= '0;
        end else begin
          j <= j + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= LW'(a);
      b_q <= LW'(b);
    end
    if (run) begin
      pp <= a_q[i] * b_q[j];
      sh <= IW'(i + j);
    end
    if (start) begin
      acc <= c;
    end else if (pp_vld) begin
      acc <= acc + shifted[WIDTH-1:0];
    end
  end

endmodule

// ===== hdl/lcg_jump_ahead_128.sv =====
// Top level of the LCG jump-ahead block: sequencer, operand registers, config.
//
//  Channel   Ports                          Handshake
//  -------   -----------------------------  -----------------------------------
//  command   command (cmd_t)                transfer when start && !busy
//  result    result (result_t)              transfer in the cycle done is high
//  config    cfg_we, cfg_index, cfg_data    write when cfg_we, no wait
//
// One item runs square-and-multiply over the step count, one bit per pass, up
// to LCG_BITS passes. Every product goes through the shared 32x32 multiplier,
// one partial product per cycle: P = NL*(NL+1)/2 partials, NL = LCG_BITS/32
// rounded up. A pass runs two such operations, or four when the step bit is
// set (am and ap first, then cp and cm); the final multiply-add follows.
// Reset is synchronous; the multiplier and increment return to 1 and 0.
// The receiver cannot stall: done is high for one cycle only.
module lcg_jump_ahead_128 #(
  parameter int LCG_BITS = lcgja_pkg::LCG_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  lcgja_pkg::cmd_t                      command,
  output logic                                 done,
  output lcgja_pkg::result_t                   result,
  input  logic                                 cfg_we,
  input  logic [lcgja_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcgja_pkg::FIELD_W-1:0]        cfg_data
);
  import lcgja_pkg::*;

  localparam int W = LCG_BITS;

  // Configuration registers, full field width; truncated to W on use.
  logic [FIELD_W-1:0] mult_high;
  logic [FIELD_W-1:0] mult_low;
  logic [FIELD_W-1:0] incr_high;
  logic [FIELD_W-1:0] incr_low;

  // Running pair for 2^i steps (cm, cp) and accumulated pair (am, ap).
  logic [W-1:0] cm;
  logic [W-1:0] cp;
  logic [W-1:0] am;
  logic [W-1:0] ap;
  logic [W-1:0] seed;
  logic [W-1:0] steps;

  lcgja_state_t state, state_next;

  logic          mul_start;
  logic [W-1:0]  mul_a;
  logic [W-1:0]  mul_b;
  logic [W-1:0]  mul_c;
  logic          mul_done;
  logic [W-1:0]  mul_prod;
  logic [FULL_W-1:0] res_full;

  assign busy     = (state != S_IDLE);
  assign res_full = FULL_W'(mul_prod);

  // Write configuration; all four indexes are defined.
  always_ff @(posedge clk) begin
    if (rst) begin
      mult_high <= '0;
      mult_low  <= FIELD_W'(1);
      incr_high <= '0;
      incr_low  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MULT_HIGH: mult_high <= cfg_data;
        REG_MULT_LOW:  mult_low  <= cfg_data;
        REG_INCR_HIGH: incr_high <= cfg_data;
        REG_INCR_LOW:  incr_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state: one pass per step bit, then the final am*state + ap.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (start) state_next = S_LOOP;
      S_LOOP: begin
        if (steps == '0) begin
          state_next = S_FIN;
        end else if (steps[0]) begin
          state_next = S_AM;
        end else begin
          state_next = S_CP;
        end
      end
      S_AM:       state_next = S_AM_WAIT;
      S_AM_WAIT:  if (mul_done) state_next = S_AP;
      S_AP:       state_next = S_AP_WAIT;
      S_AP_WAIT:  if (mul_done) state_next = S_CP;
      S_CP:       state_next = S_CP_WAIT;
      S_CP_WAIT:  if (mul_done) state_next = S_CM;
      S_CM:       state_next = S_CM_WAIT;
      S_CM_WAIT:  if (mul_done) state_next = S_LOOP;
      S_FIN:      state_next = S_FIN_WAIT;
      S_FIN_WAIT: if (mul_done) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Drive the shared unit: start in the issue states, pick the operands.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = cm;
    mul_b     = cm;
    mul_c     = '0;
    case (state)
      S_AM: begin
        mul_start = 1'b1;
        mul_a     = am;
      end
      S_AP: begin
        mul_start = 1'b1;
        mul_a     = ap;
        mul_c     = cp;
      end
      S_CP: begin
        mul_start = 1'b1;
        mul_a     = cm + W'(1);
        mul_b     = cp;
      end
      S_CM: begin
        mul_start = 1'b1;
      end
      S_FIN: begin
        mul_start = 1'b1;
        mul_a     = am;
        mul_b     = seed;
        mul_c     = ap;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FIN_WAIT) && mul_done;
    end
  end

  // Load the item on transfer, write back each product as it lands.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          seed  <= W'({command.state_high, command.state_low});
          steps <= W'({command.steps_high, command.steps_low});
          cm    <= W'({mult_high, mult_low});
          cp    <= W'({incr_high, incr_low});
          am    <= W'(1);
          ap    <= '0;
        end
      end
      S_AM_WAIT: if (mul_done) am <= mul_prod;
      S_AP_WAIT: if (mul_done) ap <= mul_prod;
      S_CP_WAIT: if (mul_done) cp <= mul_prod;
      S_CM_WAIT: begin
        if (mul_done) begin
          cm    <= mul_prod;
          steps <= steps >> 1;
        end
      end
      S_FIN_WAIT: begin
        if (mul_done) begin
          result.next_high <= res_full[FULL_W-1:FIELD_W];
          result.next_low  <= res_full[FIELD_W-1:0];
        end
      end
      default: ;
    endcase
  end

  lcgja_mul #(
    .WIDTH(W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .c     (mul_c),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // A result only follows the final multiply-add.
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FIN_WAIT) && !busy)
    else $error("result strobe without a finished multiply-add");

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // The shared unit only completes while the sequencer waits for it.
  a_mul_done_waiting: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_AM_WAIT || state == S_AP_WAIT ||
                  state == S_CP_WAIT || state == S_CM_WAIT ||
                  state == S_FIN_WAIT))
    else $error("multiplier finished outside a wait state");

  // The step count only shrinks after the squaring of the running multiplier.
  a_steps_shift: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy) && !$stable(steps)) |-> $past(state == S_CM_WAIT))
    else $error("step count changed outside the squaring write-back");

endmodule

// ===== sim/lcg_jump_ahead_128_checker.sv =====
// Checker for the LCG jump-ahead block: predicts each advanced state and compares.
`timescale 1ns / 100ps

module lcg_jump_ahead_128_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  lcgja_pkg::cmd_t                      command,
  input  logic                                 done,
  input  lcgja_pkg::result_t                   result,
  input  logic                                 cfg_we,
  input  logic [lcgja_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcgja_pkg::FIELD_W-1:0]        cfg_data,
  output int                                   mismatch_cnt,
  output int                                   pending_cnt
);
  import lcgja_pkg::*;

  logic [FIELD_W-1:0] mult_hi, mult_lo, incr_hi, incr_lo;
  result_t            expected_next[$];
  result_t            want;

  // Square-and-multiply over the step bits, LSB first; all products wrap at 128 bits.
  function automatic logic [FULL_W-1:0] advance_state(
    logic [FULL_W-1:0] seed,
    logic [FULL_W-1:0] count,
    logic [FULL_W-1:0] mult,
    logic [FULL_W-1:0] incr
  );
    logic [FULL_W-1:0] run_m, run_p, acc_m, acc_p;
    run_m = mult;
    run_p = incr;
    acc_m = 128'd1;
    acc_p = '0;
    for (int i = 0; i < FULL_W; i++) begin
      if (count[i]) begin
        acc_m = acc_m * run_m;
        acc_p = acc_p * run_m + run_p;
      end
      run_p = (run_m + 128'd1) * run_p;
      run_m = run_m * run_m;
    end
    return acc_m * seed + acc_p;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mult_hi = '0;
      mult_lo = 64'd1;
      incr_hi = '0;
      incr_lo = '0;
      expected_next.delete();
      pending_cnt <= 0;
    end else begin
      // retire the oldest expectation first: a result never belongs to this edge's command
      if (done) begin
        if (expected_next.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t checker: result %h with nothing expected", $time, result);
          mismatch_cnt++;
        end else begin
          want = expected_next.pop_front();
          if (result.next_high !== want.next_high || result.next_low !== want.next_low) begin
            if (mismatch_cnt < 10)
              $display("%0t checker: expected %h_%h got %h_%h", $time,
                       want.next_high, want.next_low, result.next_high, result.next_low);
            mismatch_cnt++;
          end
        end
      end
      if (start && !busy)
        expected_next.push_back(advance_state({command.state_high, command.state_low},
                                              {command.steps_high, command.steps_low},
                                              {mult_hi, mult_lo}, {incr_hi, incr_lo}));
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MULT_HIGH: mult_hi = cfg_data;
          REG_MULT_LOW:  mult_lo = cfg_data;
          REG_INCR_HIGH: incr_hi = cfg_data;
          REG_INCR_LOW:  incr_lo = cfg_data;
          default: ;
        endcase
      end
      pending_cnt <= expected_next.size();
    end
  end

endmodule

// ===== sim/lcg_jump_ahead_128_tb.sv =====
// Testbench top for the LCG jump-ahead block: stimulus, idling and verdict.
`timescale 1ns / 100ps

module lcg_jump_ahead_128_tb;
  import lcgja_pkg::*;

  // About 600 items plus their gaps stay far below this limit.
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int ITEMS_PER_PHASE = 97;
  localparam int NUM_PHASES = 6;
  localparam logic [FULL_W-1:0] STD_MULT = 128'h2360_ED05_1FC6_5DA4_4385_DF64_9FCC_F645;
  localparam logic [FULL_W-1:0] STD_INCR = 128'h5851_F42D_4C95_7F2D_1405_7B7E_F767_814F;
  localparam logic [FULL_W-1:0] ALL_ONES = {FULL_W{1'b1}};

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  cmd_t                 command = '0;
  logic                 done;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MULT_HIGH;
  logic [FIELD_W-1:0]   cfg_data = '0;

  int                   mismatch_cnt;
  int                   pending_cnt;
  int                   cycle_cnt = 0;
  bit                   gaps_on;
  logic [FULL_W-1:0]    phase_mult, phase_incr;

  lcg_jump_ahead_128 u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcg_jump_ahead_128_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .done         (done),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard stop: a hung handshake or a lost result must not run forever.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [FULL_W-1:0] random_wide();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Mostly random seeds, with the all-zero and all-one extremes now and then.
  function automatic logic [FULL_W-1:0] random_seed();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0)
      return '0;
    if (pick == 1)
      return ALL_ONES;
    return random_wide();
  endfunction

  // Run time grows with the bit length of the count, so keep most counts short
  // and let only a few cover the full 128 bits or a negative (wrapped) value.
  function automatic logic [FULL_W-1:0] random_count();
    int pick;
    int width;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      width = $urandom_range(0, 12);
      return random_wide() & ((128'd1 << width) - 128'd1);
    end
    if (pick < 90) begin
      width = $urandom_range(13, 64);
      return random_wide() & ((128'd1 << width) - 128'd1);
    end
    if (pick < 96)
      return random_wide();
    return '0 - {120'd0, 8'($urandom_range(1, 255))};
  endfunction

  // Present one command and hold it until the block takes it. Leave start high
  // so a back-to-back command follows without start dropping in between.
  task automatic send_item(input logic [FULL_W-1:0] seed, input logic [FULL_W-1:0] count);
    start   <= 1'b1;
    command <= {seed, count};
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a random-length idle burst, about one command in four.
  task automatic idle_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Hold off until every expected result has come back and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0 || busy);
  endtask

  // Write all four registers back to back; call only while the block is idle.
  task automatic load_config(input logic [FULL_W-1:0] mult, input logic [FULL_W-1:0] incr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MULT_HIGH;
    cfg_data  <= mult[127:64];
    @(posedge clk);
    cfg_index <= REG_MULT_LOW;
    cfg_data  <= mult[63:0];
    @(posedge clk);
    cfg_index <= REG_INCR_HIGH;
    cfg_data  <= incr[127:64];
    @(posedge clk);
    cfg_index <= REG_INCR_LOW;
    cfg_data  <= incr[63:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    gaps_on = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration is the identity map: every count returns the seed.
    send_item(random_wide(), 128'd0);
    send_item(random_wide(), 128'd5);
    idle_gap();
    send_item(ALL_ONES, ALL_ONES);
    drain();

    // Directed pass on a full-period generator: zero count, single bits at the
    // half boundaries and the top, and negative counts that wrap the long way.
    load_config(STD_MULT, STD_INCR);
    send_item('0, 128'd0);
    send_item(ALL_ONES, 128'd0);
    send_item(random_wide(), 128'd1);
    idle_gap();
    send_item(random_wide(), 128'd2);
    send_item(ALL_ONES, 128'd3);
    send_item('0, ALL_ONES);
    idle_gap();
    send_item(random_wide(), ALL_ONES - 128'd1);
    send_item(random_wide(), 128'd1 << 127);
    send_item(random_wide(), 128'd1 << 64);
    send_item(random_wide(), 128'd1 << 63);
    idle_gap();
    send_item(random_wide(), {64'd0, {64{1'b1}}});
    send_item(random_wide(), {{64{1'b1}}, 64'd0});
    send_item('0, 128'd1);
    drain();

    // Random phases, each under its own setting; the extremes come first and
    // the last phase runs with no idling at all.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          phase_mult = '0;
          phase_incr = ALL_ONES;
        end
        1: begin
          phase_mult = ALL_ONES;
          phase_incr = ALL_ONES;
        end
        2: begin
          phase_mult = 128'd1;
          phase_incr = 128'd1;
        end
        3: begin
          phase_mult = random_wide() | 128'd1;
          phase_incr = random_wide() | 128'd1;
        end
        4: begin
          phase_mult = random_wide();
          phase_incr = random_wide();
        end
        default: begin
          phase_mult = STD_MULT;
          phase_incr = STD_INCR;
        end
      endcase
      gaps_on = (phase != NUM_PHASES - 1);
      load_config(phase_mult, phase_incr);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_item(random_seed(), random_count());
        // occasionally let the pipe run dry before the next command
        if (gaps_on && $urandom_range(0, 49) == 0)
          drain();
        else
          idle_gap();
      end
      drain();
    end

    // Give a stray late result time to show up.
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
